// ----- src/mwk_pkg.sv -----
// Shared constants for the mecanum wheel kinematics block: word and fraction widths,
// derived datapath widths and configuration register indexes.
// No dependencies; used by mecanum_wheel_kinematics and mwk_checker.
package mwk_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // Rotation term product and its shifted value.
    localparam int TPROD_W = 2 * WORD_BITS;
    localparam int TERM_W  = TPROD_W - FRAC_BITS;

    // Per-lane operand into the wheel multiplier.
    localparam int SUM_W  = TERM_W + 1;
    localparam int ISUM_W = WORD_BITS + 2;

    // The operand is split into two halves so that each partial product stays narrow.
    localparam int LO_W      = SUM_W / 2;
    localparam int HI_W      = SUM_W - LO_W;
    localparam int LO_PROD_W = LO_W + WORD_BITS;
    localparam int HI_PROD_W = HI_W + WORD_BITS + 1;
    localparam int PROD_W    = SUM_W + WORD_BITS + 1;
    localparam int SHR_W     = PROD_W - FRAC_BITS;

    localparam int LIMIT_W   = WORD_BITS - 1;
    localparam int NUM_LANES = 4;
    localparam int PIPE_STAGES = 5;
    localparam int CNT_W     = $clog2(PIPE_STAGES + 1);

    localparam int IN_FIELDS   = 7;
    localparam int IN_DATA_W   = ((IN_FIELDS * WORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((NUM_LANES * WORD_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_INV_RADIUS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPAN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_SCALE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_EN     = 3'd5;

    localparam logic REQ_FWD = 1'b0;
    localparam logic REQ_INV = 1'b1;

endpackage

// ----- src/mecanum_wheel_kinematics.sv -----
// Mecanum drive forward and inverse kinematics in signed fixed point, five-stage pipeline.
// Depends on mwk_pkg for widths, register indexes and request codes.
//
// An accepted input word is registered in stages 1 to 5; its result is valid from stage 5.
// One word per cycle unless the output stalls; a stage holds only while the next is full.
// Reset: synchronous, active low; clears all stage valid bits and loads register defaults.
module mecanum_wheel_kinematics (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [mwk_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mwk_pkg::WORD_BITS-1:0]      i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // vel_x, vel_y, turn_rate, wheel_fl, wheel_rl, wheel_rr, wheel_fr (lowest first)
    input  logic [mwk_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // req_type
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // result_a, result_b, result_c, result_d (lowest first)
    output logic [mwk_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // limited
    output logic                               m_axis_tuser
);

    localparam int W  = mwk_pkg::WORD_BITS;
    localparam int F  = mwk_pkg::FRAC_BITS;
    localparam int NL = mwk_pkg::NUM_LANES;

    // Configuration registers
    logic [W-1:0]                  r_inv_radius;
    logic [W-1:0]                  r_radius_scale;
    logic [W-1:0]                  r_base_span;
    logic [W-1:0]                  r_rot_scale;
    logic [mwk_pkg::LIMIT_W-1:0]   r_speed_limit;
    logic                          r_limit_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_radius   <= W'(1) << F;
            r_radius_scale <= W'(1) << F;
            r_base_span    <= '0;
            r_rot_scale    <= '0;
            r_speed_limit  <= '1;
            r_limit_en     <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                mwk_pkg::REG_INV_RADIUS:   r_inv_radius   <= i_cfg_data;
                mwk_pkg::REG_RADIUS_SCALE: r_radius_scale <= i_cfg_data;
                mwk_pkg::REG_BASE_SPAN:    r_base_span    <= i_cfg_data;
                mwk_pkg::REG_ROT_SCALE:    r_rot_scale    <= i_cfg_data;
                mwk_pkg::REG_SPEED_LIMIT:  r_speed_limit  <= i_cfg_data[mwk_pkg::LIMIT_W-1:0];
                mwk_pkg::REG_LIMIT_EN:     r_limit_en     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stage enables: a stage loads when it is empty or its successor moves on.
    logic en1, en2, en3, en4, en5;
    logic r1_v, r2_v, r3_v, r4_v, r5_v;

    assign en5 = !r5_v || m_axis_tready;
    assign en4 = !r4_v || en5;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            if (en1) r1_v <= s_axis_tvalid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
            if (en5) r5_v <= r4_v;
        end
    end

    // ---------------- Stage 1: rotation term product and wheel sums ----------------
    logic signed [W-1:0] in_vx, in_vy, in_wz, in_fl, in_rl, in_rr, in_fr;
    logic signed [mwk_pkg::ISUM_W-1:0] x_fl, x_rl, x_rr, x_fr;
    logic signed [mwk_pkg::TPROD_W-1:0] n1_tprod;
    logic signed [mwk_pkg::ISUM_W-1:0]  n1_isum [NL-1];

    assign in_vx = s_axis_tdata[0*W +: W];
    assign in_vy = s_axis_tdata[1*W +: W];
    assign in_wz = s_axis_tdata[2*W +: W];
    assign in_fl = s_axis_tdata[3*W +: W];
    assign in_rl = s_axis_tdata[4*W +: W];
    assign in_rr = s_axis_tdata[5*W +: W];
    assign in_fr = s_axis_tdata[6*W +: W];

    always_comb begin
        x_fl = mwk_pkg::ISUM_W'(in_fl);
        x_rl = mwk_pkg::ISUM_W'(in_rl);
        x_rr = mwk_pkg::ISUM_W'(in_rr);
        x_fr = mwk_pkg::ISUM_W'(in_fr);
        n1_isum[0] =  x_fl + x_rl + x_rr + x_fr;
        n1_isum[1] = -x_fl + x_rl - x_rr + x_fr;
        n1_isum[2] = -x_fl - x_rl + x_rr + x_fr;
        n1_tprod   = $signed(in_wz) * $signed({1'b0, r_base_span});
    end

    logic                               r1_inv;
    logic signed [W-1:0]                r1_vx, r1_vy;
    logic signed [mwk_pkg::TPROD_W-1:0] r1_tprod;
    logic signed [mwk_pkg::ISUM_W-1:0]  r1_isum [NL-1];

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_inv   <= s_axis_tuser;
            r1_vx    <= in_vx;
            r1_vy    <= in_vy;
            r1_tprod <= n1_tprod;
            r1_isum  <= n1_isum;
        end
    end

    // ---------------- Stage 2: lane operands, multiplier and shift select ----------------
    logic signed [mwk_pkg::TERM_W-1:0] term;
    logic signed [mwk_pkg::SUM_W-1:0]  x_vx, x_vy, x_term;
    logic signed [mwk_pkg::SUM_W-1:0]  n2_s [NL];
    logic        [W-1:0]               n2_m [NL];
    logic        [NL-1:0]              n2_sh2;

    always_comb begin
        // Floor of the product: the arithmetic shift is just dropping the fraction bits.
        term   = r1_tprod[mwk_pkg::TPROD_W-1:F];
        x_vx   = mwk_pkg::SUM_W'(r1_vx);
        x_vy   = mwk_pkg::SUM_W'(r1_vy);
        x_term = mwk_pkg::SUM_W'(term);
        if (r1_inv == mwk_pkg::REQ_FWD) begin
            n2_s[0] = x_vx - x_vy - x_term;
            n2_s[1] = x_vx + x_vy - x_term;
            n2_s[2] = x_vx - x_vy + x_term;
            n2_s[3] = x_vx + x_vy + x_term;
            for (int k = 0; k < NL; k++) begin
                n2_m[k] = r_inv_radius;
            end
            n2_sh2 = '0;
        end else begin
            for (int k = 0; k < NL - 1; k++) begin
                n2_s[k] = mwk_pkg::SUM_W'(r1_isum[k]);
            end
            n2_s[NL-1] = '0;
            n2_m[0]    = r_radius_scale;
            n2_m[1]    = r_radius_scale;
            n2_m[2]    = r_rot_scale;
            n2_m[3]    = '0;
            // Body x and y carry the extra divide by four.
            n2_sh2     = 4'b0011;
        end
    end

    logic                              r2_inv;
    logic signed [mwk_pkg::SUM_W-1:0]  r2_s [NL];
    logic        [W-1:0]               r2_m [NL];
    logic        [NL-1:0]              r2_sh2;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_inv <= r1_inv;
            r2_s   <= n2_s;
            r2_m   <= n2_m;
            r2_sh2 <= n2_sh2;
        end
    end

    // ---------------- Stage 3: partial products ----------------
    logic        [mwk_pkg::LO_PROD_W-1:0] n3_lo [NL];
    logic signed [mwk_pkg::HI_PROD_W-1:0] n3_hi [NL];

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            n3_lo[k] = r2_s[k][mwk_pkg::LO_W-1:0] * r2_m[k];
            n3_hi[k] = $signed(r2_s[k][mwk_pkg::SUM_W-1:mwk_pkg::LO_W])
                       * $signed({1'b0, r2_m[k]});
        end
    end

    logic                                 r3_inv;
    logic        [mwk_pkg::LO_PROD_W-1:0] r3_lo [NL];
    logic signed [mwk_pkg::HI_PROD_W-1:0] r3_hi [NL];
    logic        [NL-1:0]                 r3_sh2;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_inv <= r2_inv;
            r3_lo  <= n3_lo;
            r3_hi  <= n3_hi;
            r3_sh2 <= r2_sh2;
        end
    end

    // ---------------- Stage 4: combine partial products and shift ----------------
    logic signed [mwk_pkg::PROD_W-1:0] prod [NL];
    logic signed [mwk_pkg::PROD_W-1:0] shr  [NL];
    logic signed [mwk_pkg::SHR_W-1:0]  n4_q [NL];

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            prod[k] = (mwk_pkg::PROD_W'(r3_hi[k]) <<< mwk_pkg::LO_W)
                      + mwk_pkg::PROD_W'(r3_lo[k]);
            shr[k]  = r3_sh2[k] ? (prod[k] >>> (F + 2)) : (prod[k] >>> F);
            n4_q[k] = shr[k][mwk_pkg::SHR_W-1:0];
        end
    end

    logic                              r4_inv;
    logic signed [mwk_pkg::SHR_W-1:0]  r4_q [NL];

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_inv <= r3_inv;
            r4_q   <= n4_q;
        end
    end

    // ---------------- Stage 5: word saturation and speed clamp ----------------
    logic [mwk_pkg::SHR_W-W:0] top  [NL];
    logic [NL-1:0]             ovf;
    logic [NL-1:0]             clamp;
    logic signed [W-1:0]       n5_r [NL];
    logic signed [W-1:0]       lim, nlim;
    logic                      n5_flag;

    always_comb begin
        lim  = $signed({1'b0, r_speed_limit});
        nlim = -lim;
        for (int k = 0; k < NL; k++) begin
            top[k] = r4_q[k][mwk_pkg::SHR_W-1:W-1];
            // Fits the word only when every bit above the sign matches it.
            ovf[k] = !((&top[k]) || !(|top[k]));
            if (ovf[k]) begin
                n5_r[k] = r4_q[k][mwk_pkg::SHR_W-1] ? {1'b1, {(W-1){1'b0}}}
                                                    : {1'b0, {(W-1){1'b1}}};
            end else begin
                n5_r[k] = r4_q[k][W-1:0];
            end
            clamp[k] = 1'b0;
            if (r4_inv == mwk_pkg::REQ_FWD && r_limit_en) begin
                if (n5_r[k] > lim) begin
                    n5_r[k]  = lim;
                    clamp[k] = 1'b1;
                end else if (n5_r[k] < nlim) begin
                    n5_r[k]  = nlim;
                    clamp[k] = 1'b1;
                end
            end
        end
        n5_flag = (|ovf) || (|clamp);
    end

    logic signed [W-1:0] r5_r [NL];
    logic                r5_flag;

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_r    <= n5_r;
            r5_flag <= n5_flag;
        end
    end

    assign m_axis_tvalid = r5_v;
    assign m_axis_tuser  = r5_flag;
    assign m_axis_tdata  = mwk_pkg::OUT_DATA_W'({r5_r[3], r5_r[2], r5_r[1], r5_r[0]});

endmodule

// ----- src/mwk_checker.sv -----
// Port-level checks for mecanum_wheel_kinematics, attached by the bind at the end.
// Depends on mwk_pkg for port widths and the pipeline depth.
module mwk_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [mwk_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input logic                               m_axis_tuser
);

    // Words accepted but not yet delivered.
    logic [mwk_pkg::CNT_W-1:0] r_cnt;
    logic [mwk_pkg::CNT_W-1:0] n_cnt;
    logic                      in_acc, out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign n_cnt   = r_cnt + mwk_pkg::CNT_W'(in_acc) - mwk_pkg::CNT_W'(out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= mwk_pkg::CNT_W'(mwk_pkg::PIPE_STAGES))
        else $error("more words in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_cnt != '0)
        else $error("result word shown with nothing accepted");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == '0 |-> s_axis_tready)
        else $error("empty pipeline refuses input");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result word changed");

endmodule

bind mecanum_wheel_kinematics mwk_checker u_mwk_checker (.*);

// ----- bench/tb.sv -----
// Self-checking bench for mecanum_wheel_kinematics: forward and inverse requests under
// several register settings, with random idling on both stream sides and one long output stall.
// Depends on mwk_pkg and the mecanum_wheel_kinematics RTL only.
`timescale 1ns / 1ps

module tb;
    import mwk_pkg::*;

    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN = 32'h8000_0000;
    localparam logic [31:0] ONE_Q16  = 32'h0001_0000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int PHASES         = 10;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int SETTLE_CYCLES  = 10;
    localparam int HOLD_CYCLES    = 120;
    localparam int STALL_LIMIT    = 5000;

    typedef struct packed {
        logic              req_type;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] turn_rate;
        logic signed [31:0] wheel_fl;
        logic signed [31:0] wheel_rl;
        logic signed [31:0] wheel_rr;
        logic signed [31:0] wheel_fr;
    } kin_request_t;

    typedef struct packed {
        logic signed [31:0] res_a;
        logic signed [31:0] res_b;
        logic signed [31:0] res_c;
        logic signed [31:0] res_d;
        logic              limited;
    } kin_result_t;

    // Holds a private copy of the registers and the queue of predicted result words.
    class kin_scoreboard;
        logic [31:0] inv_radius;
        logic [31:0] radius_scale;
        logic [31:0] base_span;
        logic [31:0] rot_scale;
        logic [30:0] speed_limit;
        logic        limit_enable;
        kin_result_t expected_q[$];
        int          errors;

        function new();
            inv_radius   = ONE_Q16;
            radius_scale = ONE_Q16;
            base_span    = '0;
            rot_scale    = '0;
            speed_limit  = '1;
            limit_enable = 1'b1;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_INV_RADIUS:   inv_radius   = data;
                REG_RADIUS_SCALE: radius_scale = data;
                REG_BASE_SPAN:    base_span    = data;
                REG_ROT_SCALE:    rot_scale    = data;
                REG_SPEED_LIMIT:  speed_limit  = data[30:0];
                REG_LIMIT_EN:     limit_enable = data[0];
                default: ;
            endcase
        endfunction

        // Exact product, then an arithmetic shift, which rounds towards minus infinity.
        function logic signed [127:0] floor_mul(logic signed [127:0] opnd, logic [31:0] factor,
                                                int sh);
            logic signed [127:0] f;
            f = {96'd0, factor};
            return (opnd * f) >>> sh;
        endfunction

        function logic signed [31:0] to_word(logic signed [127:0] v, inout logic flag);
            if (v > 128'sh7FFF_FFFF) begin
                flag = 1'b1;
                return 32'sh7FFF_FFFF;
            end
            if (v < -128'sh8000_0000) begin
                flag = 1'b1;
                return 32'sh8000_0000;
            end
            return v[31:0];
        endfunction

        function kin_result_t kinematics(kin_request_t rq);
            logic signed [127:0] vx, vy, term, fl, rl, rr, fr;
            logic signed [127:0] lane [4];
            logic signed [31:0]  w [4];
            logic signed [31:0]  lim;
            logic                flag;
            kin_result_t         res;
            flag = 1'b0;
            if (rq.req_type == REQ_FWD) begin
                vx   = $signed(rq.vel_x);
                vy   = $signed(rq.vel_y);
                term = floor_mul($signed(rq.turn_rate), base_span, FRAC_BITS);
                lane[0] = vx - vy - term;
                lane[1] = vx + vy - term;
                lane[2] = vx - vy + term;
                lane[3] = vx + vy + term;
                lim = $signed({1'b0, speed_limit});
                for (int k = 0; k < 4; k++) begin
                    w[k] = to_word(floor_mul(lane[k], inv_radius, FRAC_BITS), flag);
                    // A wheel speed sitting exactly on the limit is not counted as clamped.
                    if (limit_enable) begin
                        if (w[k] > lim) begin
                            w[k] = lim;
                            flag = 1'b1;
                        end
                        if (w[k] < -lim) begin
                            w[k] = -lim;
                            flag = 1'b1;
                        end
                    end
                end
            end else begin
                fl = $signed(rq.wheel_fl);
                rl = $signed(rq.wheel_rl);
                rr = $signed(rq.wheel_rr);
                fr = $signed(rq.wheel_fr);
                w[0] = to_word(floor_mul(fl + rl + rr + fr, radius_scale, FRAC_BITS + 2), flag);
                w[1] = to_word(floor_mul(-fl + rl - rr + fr, radius_scale, FRAC_BITS + 2), flag);
                w[2] = to_word(floor_mul(-fl - rl + rr + fr, rot_scale, FRAC_BITS), flag);
                w[3] = '0;
            end
            res.res_a   = w[0];
            res.res_b   = w[1];
            res.res_c   = w[2];
            res.res_d   = w[3];
            res.limited = flag;
            return res;
        endfunction

        function void note_request(kin_request_t rq);
            expected_q.push_back(kinematics(rq));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic flag);
            kin_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing expected: expected none, actual %h/%b",
                         $time, data, flag);
                return;
            end
            want = expected_q.pop_front();
            compare_field("result_a", want.res_a, data[31:0]);
            compare_field("result_b", want.res_b, data[63:32]);
            compare_field("result_c", want.res_c, data[95:64]);
            compare_field("result_d", want.res_d, data[127:96]);
            compare_field("limited", {31'd0, want.limited}, {31'd0, flag});
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [WORD_BITS-1:0]  i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    kin_scoreboard sb;
    int send_idle_pct;
    int rcv_stall_pct;
    int hold_left;
    bit hold_go;
    int stall_cycles;

    mecanum_wheel_kinematics dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Output side: random back-pressure, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_go) begin
            hold_left = HOLD_CYCLES;
            hold_go   = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("** mecanum_wheel_kinematics: FAILED **");
        $finish;
    end

    // Biased towards the extremes and towards small values, where clamping is interesting.
    function automatic logic [31:0] pick_word();
        logic [31:0] mag;
        case ($urandom_range(9))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return 32'hFFFF_FFFF;
            4, 5: mag = $urandom_range(32'h0004_0000);
            6, 7: mag = $urandom >> 8;
            default: return $urandom;
        endcase
        return $urandom_range(1) ? -mag : mag;
    endfunction

    function automatic logic [31:0] pick_reg_value();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2, 3: return 32'h0000_4000 + $urandom_range(32'h0003_0000);
            default: return $urandom;
        endcase
    endfunction

    // The fields of the other mode carry random values, which the block must ignore.
    function automatic kin_request_t fwd_request(logic [31:0] vx, logic [31:0] vy,
                                                  logic [31:0] wz);
        kin_request_t rq;
        rq.req_type  = REQ_FWD;
        rq.vel_x     = vx;
        rq.vel_y     = vy;
        rq.turn_rate = wz;
        rq.wheel_fl  = $urandom;
        rq.wheel_rl  = $urandom;
        rq.wheel_rr  = $urandom;
        rq.wheel_fr  = $urandom;
        return rq;
    endfunction

    function automatic kin_request_t inv_request(logic [31:0] fl, logic [31:0] rl,
                                                  logic [31:0] rr, logic [31:0] fr);
        kin_request_t rq;
        rq.req_type  = REQ_INV;
        rq.vel_x     = $urandom;
        rq.vel_y     = $urandom;
        rq.turn_rate = $urandom;
        rq.wheel_fl  = fl;
        rq.wheel_rl  = rl;
        rq.wheel_rr  = rr;
        rq.wheel_fr  = fr;
        return rq;
    endfunction

    function automatic kin_request_t random_request();
        kin_request_t rq;
        rq.req_type  = $urandom_range(1) ? REQ_INV : REQ_FWD;
        rq.vel_x     = pick_word();
        rq.vel_y     = pick_word();
        rq.turn_rate = pick_word();
        rq.wheel_fl  = pick_word();
        rq.wheel_rl  = pick_word();
        rq.wheel_rr  = pick_word();
        rq.wheel_fr  = pick_word();
        return rq;
    endfunction

    task automatic offer(kin_request_t rq);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rq.wheel_fr, rq.wheel_rr, rq.wheel_rl, rq.wheel_fl,
                          rq.turn_rate, rq.vel_y, rq.vel_x};
        s_axis_tuser  <= rq.req_type;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(rq);
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_FWD;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        hold_left     = 0;
        hold_go       = 1'b0;
        stall_cycles  = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: zero base span, so the rotation term vanishes.
        offer(fwd_request('0, '0, '0));
        offer(fwd_request(WORD_MAX, WORD_MIN, WORD_MAX));
        offer(fwd_request(WORD_MIN, WORD_MAX, WORD_MIN));
        offer(fwd_request(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF));
        offer(inv_request(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
        offer(inv_request(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
        offer(inv_request(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX));
        offer(inv_request(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF));
        end_burst();
        wait_idle();

        // Half a radius reciprocal and a limit of 3.0: exact limit, one past it, and rounding.
        write_reg(REG_BASE_SPAN, 32'h0002_0000);
        write_reg(REG_ROT_SCALE, 32'h0000_4000);
        write_reg(REG_SPEED_LIMIT, 32'h0003_0000);
        write_reg(REG_INV_RADIUS, 32'h0000_8000);
        write_reg(REG_RADIUS_SCALE, 32'h0002_0000);
        offer(fwd_request(32'h0006_0000, '0, '0));
        offer(fwd_request(32'h0006_0002, '0, '0));
        offer(fwd_request(32'hFFFA_0000, '0, '0));
        offer(fwd_request(32'hFFFF_FFFF, '0, '0));
        offer(fwd_request('0, '0, ONE_Q16));
        offer(fwd_request(ONE_Q16, 32'h0000_8000, 32'hFFFF_8000));
        offer(inv_request(ONE_Q16, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000));
        end_burst();
        wait_idle();

        // Limiting off: only word saturation raises the flag. Spare indexes must do nothing.
        write_reg(REG_LIMIT_EN, '0);
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        offer(fwd_request(WORD_MAX, WORD_MAX, WORD_MAX));
        offer(fwd_request(32'h0010_0000, '0, '0));
        end_burst();
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; rcv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rcv_stall_pct = 56; end
                default: begin send_idle_pct = 19; rcv_stall_pct = 19; end
            endcase
            if (p == 0) begin
                write_reg(REG_INV_RADIUS, '1);
                write_reg(REG_RADIUS_SCALE, '1);
                write_reg(REG_BASE_SPAN, '1);
                write_reg(REG_ROT_SCALE, '1);
                write_reg(REG_SPEED_LIMIT, WORD_MAX);
                write_reg(REG_LIMIT_EN, 32'd1);
            end else if (p == 1) begin
                write_reg(REG_INV_RADIUS, '0);
                write_reg(REG_RADIUS_SCALE, '0);
                write_reg(REG_BASE_SPAN, '0);
                write_reg(REG_ROT_SCALE, '0);
                write_reg(REG_SPEED_LIMIT, '0);
            end else begin
                write_reg(REG_INV_RADIUS, pick_reg_value());
                write_reg(REG_RADIUS_SCALE, pick_reg_value());
                write_reg(REG_BASE_SPAN, pick_reg_value());
                write_reg(REG_ROT_SCALE, pick_reg_value());
                write_reg(REG_SPEED_LIMIT, pick_reg_value());
                write_reg(REG_LIMIT_EN, $urandom_range(1));
                if ($urandom_range(1))
                    write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
            end
            // One phase blocks the output long enough for the pipeline to back up.
            if (p == 4) begin
                @(posedge i_clk);
                hold_go = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                offer(random_request());
            end_burst();
            wait_idle();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("** mecanum_wheel_kinematics: PASSED **");
        else
            $display("** mecanum_wheel_kinematics: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
src/mwk_pkg.sv
src/mecanum_wheel_kinematics.sv
src/mwk_checker.sv
bench/tb.sv
